// File: rtl/stc_pkg.sv
// Package for the shell token classifier: modes, classes, character tests and keyword table.
package stc_pkg;

  localparam int SpanLenBitsDef   = 16;
  localparam int NestDepthBitsDef = 8;
  localparam int KeywordMaxDef    = 8;
  localparam int OutLenBits       = 16;
  localparam int KwCount          = 16;
  localparam int KwLenMax         = 8;

  typedef enum logic [3:0] {
    M_IDLE, M_WS, M_COMMENT, M_SQ, M_DQ, M_VSTART, M_VBRACE, M_VPAREN,
    M_VNAME, M_ESC, M_OP, M_WORD
  } mode_t;

  typedef enum logic [2:0] {
    CL_PLAIN, CL_COMMAND, CL_KEYWORD, CL_OPTION, CL_STRING, CL_VARIABLE,
    CL_OPERATOR, CL_COMMENT
  } class_t;

  // Keyword lookup result handed from the matcher to the core.
  typedef struct packed {
    logic hit;
    logic to_cmd;
  } kw_res_t;

  typedef struct packed {
    logic [63:0] text;
    logic [3:0]  len;
    logic        to_cmd;
  } kw_entry_t;

  localparam kw_entry_t KwTable [KwCount] = '{
    '{64'h63617365_00000000, 4'd4, 1'b0}, // case
    '{64'h646f0000_00000000, 4'd2, 1'b1}, // do
    '{64'h646f6e65_00000000, 4'd4, 1'b0}, // done
    '{64'h656c6966_00000000, 4'd4, 1'b1}, // elif
    '{64'h656c7365_00000000, 4'd4, 1'b1}, // else
    '{64'h65736163_00000000, 4'd4, 1'b0}, // esac
    '{64'h66690000_00000000, 4'd2, 1'b0}, // fi
    '{64'h666f7200_00000000, 4'd3, 1'b0}, // for
    '{64'h66756e63_74696f6e, 4'd8, 1'b0}, // function
    '{64'h69660000_00000000, 4'd2, 1'b1}, // if
    '{64'h696e0000_00000000, 4'd2, 1'b0}, // in
    '{64'h73656c65_63740000, 4'd6, 1'b0}, // select
    '{64'h7468656e_00000000, 4'd4, 1'b1}, // then
    '{64'h74696d65_00000000, 4'd4, 1'b1}, // time
    '{64'h756e7469_6c000000, 4'd5, 1'b1}, // until
    '{64'h7768696c_65000000, 4'd5, 1'b1}  // while
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == 8'h7c || c == 8'h26 || c == 8'h3b || c == 8'h28 || c == 8'h29 ||
           c == 8'h3c || c == 8'h3e;
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    if (a == b && (a == 8'h26 || a == 8'h7c || a == 8'h3e || a == 8'h3c || a == 8'h3b))
      return 1'b1;
    return b == 8'h26 && (a == 8'h7c || a == 8'h3e || a == 8'h3c);
  endfunction

endpackage

// File: rtl/stc_kw_match.sv
// Parallel keyword compare of the buffered word prefix against the keyword table.
module stc_kw_match #(
  parameter int KEYWORD_MAX = stc_pkg::KeywordMaxDef,
  parameter int LEN_BITS    = 16
) (
  input  logic [KEYWORD_MAX-1:0][7:0] prefix,
  input  logic [LEN_BITS-1:0]         word_len,
  output stc_pkg::kw_res_t            result
);

  // Each table entry compares its own length and bytes; entries are disjoint.
  always_comb begin
    logic match;
    result = '0;
    for (int i = 0; i < stc_pkg::KwCount; i++) begin
      match = (word_len == LEN_BITS'(stc_pkg::KwTable[i].len));
      for (int j = 0; j < stc_pkg::KwLenMax; j++) begin
        if (j < int'(stc_pkg::KwTable[i].len)) begin
          if (prefix[j] != stc_pkg::KwTable[i].text[63-8*j -: 8]) match = 1'b0;
        end
      end
      if (match) begin
        result.hit    = 1'b1;
        result.to_cmd = stc_pkg::KwTable[i].to_cmd;
      end
    end
  end

endmodule

// File: rtl/shell_token_classifier_core.sv
// Top level of the shell token classifier: lexer state update and result queue.
//
// Usage: shell source enters on the in_ channel, one byte per transfer, with
// in_final_byte marking the last byte. Each transfer closes zero, one or two
// token spans; they leave on the out_ channel as (length, class, clip flag,
// end-of-source flag), one span per transfer, in source order.
// A span is registered into the result queue as the byte that closes it is taken.
// Throughput: one byte per cycle while each byte yields at most one span. The
// two-entry result queue sets the rate: a byte that yields two spans, or a
// stalled output, fills it, and in_stall rises while fewer than two entries
// are free. The state update is one combinational pass per byte.
// Reset: rst_n low (synchronous) returns the lexer to idle, no token open,
// command expected, and empties the result queue. The state also returns to
// reset after every byte with in_final_byte high.
// When out_stall is high the head span holds; input continues until the
// queue can no longer take a worst-case byte.
module shell_token_classifier_core #(
  parameter int SPAN_LEN_BITS   = stc_pkg::SpanLenBitsDef,
  parameter int NEST_DEPTH_BITS = stc_pkg::NestDepthBitsDef,
  parameter int KEYWORD_MAX     = stc_pkg::KeywordMaxDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_span_length,
  output logic [2:0]  out_span_class,
  output logic        out_length_clipped,
  output logic        out_end_of_source
);

  localparam int SL = SPAN_LEN_BITS;
  localparam int ND = NEST_DEPTH_BITS;
  localparam logic [SL-1:0] SpanMax  = '1;
  localparam logic [ND-1:0] DepthMax = '1;
  localparam int QW = stc_pkg::OutLenBits + 3 + 1 + 1;

  // Lexer state.
  stc_pkg::mode_t            mode_r, mode_nxt;
  logic [SL-1:0]             cnt_r, cnt_nxt;
  logic                      clip_r, clip_nxt;
  logic                      ecmd_r, ecmd_nxt;
  logic                      wst_r, wst_nxt;
  logic [KEYWORD_MAX-1:0][7:0] pfx_r, pfx_nxt;
  logic [1:0]                asg_r, asg_nxt;
  logic                      dash_r, dash_nxt;
  logic                      dqe_r, dqe_nxt;
  logic [ND-1:0]             dep_r, dep_nxt;
  logic [7:0]                pop_r, pop_nxt;

  // Result queue, two entries.
  logic [1:0][QW-1:0] q_r, q_nxt;
  logic [1:0]         qn_r, qn_nxt;

  logic            take, pop;
  logic [7:0]      c;
  logic            fin;
  stc_pkg::kw_res_t kw;

  logic [1:0]          en;
  logic [1:0][QW-1:0]  em;

  assign c    = in_text_byte;
  assign fin  = in_final_byte;
  assign in_stall = (qn_r != 2'd0) && !(qn_r == 2'd1 && !out_stall);
  assign take = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  stc_kw_match #(.KEYWORD_MAX(KEYWORD_MAX), .LEN_BITS(SL)) u_kw (
    .prefix   (pfx_r),
    .word_len (cnt_r),
    .result   (kw)
  );

  // One combinational pass per byte, following the token rules.
  always_comb begin
    logic absorbed;
    logic kw_ok;
    logic opcmd;
    mode_nxt = mode_r; cnt_nxt = cnt_r; clip_nxt = clip_r; ecmd_nxt = ecmd_r;
    wst_nxt = wst_r; pfx_nxt = pfx_r; asg_nxt = asg_r; dash_nxt = dash_r;
    dqe_nxt = dqe_r; dep_nxt = dep_r; pop_nxt = pop_r;
    en = '0; em = '0;
    absorbed = 1'b0; opcmd = 1'b0;
    kw_ok = kw.hit && !clip_r && (cnt_r <= SL'(KEYWORD_MAX));

    if (take) begin
      // Continue the open token.
      unique case (mode_r)
        stc_pkg::M_WS: begin
          if (!stc_pkg::is_space(c)) emit_span(stc_pkg::CL_PLAIN);
          else begin
            if (c == 8'h0a) ecmd_nxt = 1'b1;
            add_byte(); absorbed = 1'b1;
          end
        end
        stc_pkg::M_COMMENT: begin
          if (c == 8'h0a) emit_span(stc_pkg::CL_COMMENT);
          else begin add_byte(); absorbed = 1'b1; end
        end
        stc_pkg::M_SQ: begin
          add_byte(); absorbed = 1'b1;
          if (c == 8'h27) emit_span(stc_pkg::CL_STRING);
        end
        stc_pkg::M_DQ: begin
          add_byte(); absorbed = 1'b1;
          if (dqe_r) dqe_nxt = 1'b0;
          else if (c == 8'h5c && !fin) dqe_nxt = 1'b1;
          else if (c == 8'h22) emit_span(stc_pkg::CL_STRING);
        end
        stc_pkg::M_VSTART: begin
          add_byte(); absorbed = 1'b1;
          if (c == 8'h7b) mode_nxt = stc_pkg::M_VBRACE;
          else if (c == 8'h28) begin dep_nxt = ND'(1); mode_nxt = stc_pkg::M_VPAREN; end
          else if (stc_pkg::is_name(c)) mode_nxt = stc_pkg::M_VNAME;
          else emit_span(stc_pkg::CL_VARIABLE);
        end
        stc_pkg::M_VBRACE: begin
          add_byte(); absorbed = 1'b1;
          if (c == 8'h7d) emit_span(stc_pkg::CL_VARIABLE);
        end
        stc_pkg::M_VPAREN: begin
          add_byte(); absorbed = 1'b1;
          if (c == 8'h28) begin
            if (dep_r != DepthMax) dep_nxt = dep_r + ND'(1);
          end else if (c == 8'h29) begin
            if (dep_r != '0) dep_nxt = dep_r - ND'(1);
          end
          if (dep_nxt == '0) emit_span(stc_pkg::CL_VARIABLE);
        end
        stc_pkg::M_VNAME: begin
          if (!stc_pkg::is_name(c)) emit_span(stc_pkg::CL_VARIABLE);
          else begin add_byte(); absorbed = 1'b1; end
        end
        stc_pkg::M_ESC: begin
          add_byte(); absorbed = 1'b1; emit_span(stc_pkg::CL_STRING);
        end
        stc_pkg::M_OP: begin
          if (stc_pkg::is_pair(pop_r, c)) begin
            add_byte(); absorbed = 1'b1;
            opcmd = (pop_r == c && (c == 8'h3b || c == 8'h7c || c == 8'h26)) ||
                    (pop_r == 8'h7c && c == 8'h26);
          end else begin
            opcmd = pop_r == 8'h3b || pop_r == 8'h7c || pop_r == 8'h26 || pop_r == 8'h28;
          end
          if (opcmd) ecmd_nxt = 1'b1;
          wst_nxt = 1'b1;
          emit_span(stc_pkg::CL_OPERATOR);
        end
        stc_pkg::M_WORD: begin
          if (stc_pkg::is_space(c) || stc_pkg::is_op(c) || c == 8'h27 || c == 8'h22 ||
              c == 8'h24 || c == 8'h5c) begin
            close_word(kw_ok);
          end else begin
            absorbed = 1'b1;
            for (int i = 0; i < KEYWORD_MAX; i++)
              if (cnt_r == SL'(i)) pfx_nxt[i] = c;
            if (asg_r == 2'd0) begin
              if (c == 8'h3d) asg_nxt = 2'd1;
              else if (!stc_pkg::is_name(c)) asg_nxt = 2'd2;
            end
            add_byte();
          end
        end
        default: absorbed = 1'b0;
      endcase

      // Open a new token with this byte.
      if (!absorbed) begin
        priority if (stc_pkg::is_space(c)) begin
          if (c == 8'h0a) ecmd_nxt = 1'b1;
          wst_nxt = 1'b1; mode_nxt = stc_pkg::M_WS; cnt_nxt = SL'(1);
        end else if (c == 8'h23 && wst_nxt) begin
          mode_nxt = stc_pkg::M_COMMENT; cnt_nxt = SL'(1);
        end else if (c == 8'h27) begin
          value_start(stc_pkg::M_SQ);
        end else if (c == 8'h22) begin
          dqe_nxt = 1'b0; value_start(stc_pkg::M_DQ);
        end else if (c == 8'h24) begin
          value_start(stc_pkg::M_VSTART);
        end else if (c == 8'h5c && !fin) begin
          value_start(stc_pkg::M_ESC);
        end else if (stc_pkg::is_op(c)) begin
          pop_nxt = c; mode_nxt = stc_pkg::M_OP; cnt_nxt = SL'(1);
        end else begin
          wst_nxt = 1'b0; mode_nxt = stc_pkg::M_WORD; cnt_nxt = SL'(1);
          asg_nxt = (stc_pkg::is_alpha(c) || c == 8'h5f) ? 2'd0 : 2'd2;
          dash_nxt = (c == 8'h2d);
          pfx_nxt[0] = c;
        end
      end

      // Close whatever is open at the end of the source.
      if (fin) begin
        unique case (mode_nxt)
          stc_pkg::M_WS:      emit_span(stc_pkg::CL_PLAIN);
          stc_pkg::M_COMMENT: emit_span(stc_pkg::CL_COMMENT);
          stc_pkg::M_SQ, stc_pkg::M_DQ, stc_pkg::M_ESC: emit_span(stc_pkg::CL_STRING);
          stc_pkg::M_VSTART, stc_pkg::M_VBRACE, stc_pkg::M_VPAREN, stc_pkg::M_VNAME:
            emit_span(stc_pkg::CL_VARIABLE);
          stc_pkg::M_OP:      emit_span(stc_pkg::CL_OPERATOR);
          stc_pkg::M_WORD:    close_final_word();
          default: ;
        endcase
        if (en[1]) em[1][0] = 1'b1;
        else if (en[0]) em[0][0] = 1'b1;
        mode_nxt = stc_pkg::M_IDLE; cnt_nxt = '0; clip_nxt = 1'b0; ecmd_nxt = 1'b1;
        wst_nxt = 1'b1; asg_nxt = 2'd0; dash_nxt = 1'b0; dqe_nxt = 1'b0;
        dep_nxt = '0; pop_nxt = 8'h00;
      end
    end
  end

  // Count one byte into the open span, saturating.
  function automatic void add_byte();
    if (cnt_nxt == SpanMax) clip_nxt = 1'b1;
    else cnt_nxt = cnt_nxt + SL'(1);
  endfunction

  // Record a finished span into the next free emit slot and close the token.
  function automatic void emit_span(input stc_pkg::class_t cls);
    logic [stc_pkg::OutLenBits-1:0] len;
    len = stc_pkg::OutLenBits'(cnt_nxt);
    if (!en[0]) begin
      en[0] = 1'b1; em[0] = {len, cls, clip_nxt, 1'b0};
    end else begin
      en[1] = 1'b1; em[1] = {len, cls, clip_nxt, 1'b0};
    end
    cnt_nxt = '0; clip_nxt = 1'b0; mode_nxt = stc_pkg::M_IDLE;
  endfunction

  function automatic void value_start(input stc_pkg::mode_t m);
    if (wst_nxt && ecmd_nxt) ecmd_nxt = 1'b0;
    wst_nxt = 1'b0; mode_nxt = m; cnt_nxt = SL'(1);
  endfunction

  // Classify a finished word; ok says the stored prefix matched a keyword.
  function automatic void close_word(input logic ok);
    wst_nxt = 1'b0;
    if (ok) begin ecmd_nxt = kw.to_cmd; emit_span(stc_pkg::CL_KEYWORD); end
    else if (ecmd_nxt && asg_nxt == 2'd1) emit_span(stc_pkg::CL_VARIABLE);
    else if (ecmd_nxt) begin ecmd_nxt = 1'b0; emit_span(stc_pkg::CL_COMMAND); end
    else if (dash_nxt) emit_span(stc_pkg::CL_OPTION);
    else emit_span(stc_pkg::CL_PLAIN);
  endfunction

  // A word still open at the last byte needs the keyword test on the updated prefix.
  function automatic void close_final_word();
    logic hit, tc, m;
    hit = 1'b0; tc = 1'b0;
    if (!clip_nxt && cnt_nxt <= SL'(KEYWORD_MAX)) begin
      for (int i = 0; i < stc_pkg::KwCount; i++) begin
        m = (cnt_nxt == SL'(stc_pkg::KwTable[i].len));
        for (int j = 0; j < stc_pkg::KwLenMax; j++)
          if (j < int'(stc_pkg::KwTable[i].len) && j < KEYWORD_MAX)
            if (pfx_nxt[j] != stc_pkg::KwTable[i].text[63-8*j -: 8]) m = 1'b0;
        if (m) begin hit = 1'b1; tc = stc_pkg::KwTable[i].to_cmd; end
      end
    end
    wst_nxt = 1'b0;
    if (hit) begin ecmd_nxt = tc; emit_span(stc_pkg::CL_KEYWORD); end
    else if (ecmd_nxt && asg_nxt == 2'd1) emit_span(stc_pkg::CL_VARIABLE);
    else if (ecmd_nxt) begin ecmd_nxt = 1'b0; emit_span(stc_pkg::CL_COMMAND); end
    else if (dash_nxt) emit_span(stc_pkg::CL_OPTION);
    else emit_span(stc_pkg::CL_PLAIN);
  endfunction

  // Queue update: pop the head, then append the new spans.
  always_comb begin
    logic [1:0] base;
    q_nxt = q_r;
    base  = qn_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      base = qn_r - 2'd1;
    end
    if (en[0]) q_nxt[base[0]] = em[0];
    if (en[1]) q_nxt[1] = em[1];
    qn_nxt = base + 2'(en[0]) + 2'(en[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stc_pkg::M_IDLE; cnt_r <= '0; clip_r <= 1'b0; ecmd_r <= 1'b1;
      wst_r <= 1'b1; asg_r <= 2'd0; dash_r <= 1'b0; dqe_r <= 1'b0;
      dep_r <= '0; pop_r <= 8'h00; qn_r <= 2'd0;
    end else begin
      mode_r <= mode_nxt; cnt_r <= cnt_nxt; clip_r <= clip_nxt; ecmd_r <= ecmd_nxt;
      wst_r <= wst_nxt; asg_r <= asg_nxt; dash_r <= dash_nxt; dqe_r <= dqe_nxt;
      dep_r <= dep_nxt; pop_r <= pop_nxt; qn_r <= qn_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    pfx_r <= pfx_nxt;
    q_r   <= q_nxt;
  end

  assign out_valid = (qn_r != 2'd0);
  assign {out_span_length, out_span_class, out_length_clipped, out_end_of_source} = q_r[0];

`ifndef SYNTH
  // The queue never holds more than two spans.
  a_qn_bound: assert property (@(posedge clk) disable iff (!rst_n) qn_r != 2'd3)
    else $error("result queue overflow");
  // A full queue refuses input.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    qn_r == 2'd2 |-> in_stall) else $error("input taken with full queue");
  // After a final byte the lexer is back at idle.
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && fin |=> mode_r == stc_pkg::M_IDLE && cnt_r == '0)
    else $error("state not cleared after final byte");
  // Every emitted span has a nonzero length unless clipped.
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_length != '0 || out_length_clipped))
    else $error("empty span emitted");
`endif

endmodule

// File: bench/tb_shell_token_classifier_core.sv
// Self-checking testbench for shell_token_classifier_core: byte stream in, token spans out.
module tb_shell_token_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SpanMax  = 65535;
  localparam int unsigned DepthMax = 255;
  localparam int          LimitCycles = 200000;

  typedef struct {
    logic [15:0]     length;
    stc_pkg::class_t cls;
    logic            clipped;
    logic            eos;
  } span_t;

  // Span lexer mirror plus the list of spans still owed by the block.
  class span_scoreboard;
    span_t  owed[$];
    int     mismatches;
    stc_pkg::mode_t mode;
    int unsigned cnt;
    bit     clip, expect_cmd, word_start, dash_lead, dq_esc;
    bit [7:0] prefix[8];
    bit [1:0] assign_track;
    int unsigned depth;
    bit [7:0] pend_op;
    int     step_spans;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      mode = stc_pkg::M_IDLE; cnt = 0; clip = 0; expect_cmd = 1; word_start = 1;
      assign_track = 0; dash_lead = 0; dq_esc = 0; depth = 0; pend_op = 0;
      foreach (prefix[i]) prefix[i] = 0;
    endfunction

    function bit sp(bit [7:0] c);
      return c == 8'h20 || (c >= 9 && c <= 13);
    endfunction
    function bit al(bit [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function bit nm(bit [7:0] c);
      return al(c) || (c >= "0" && c <= "9") || c == "_";
    endfunction
    function bit opc(bit [7:0] c);
      return c == "|" || c == "&" || c == ";" || c == "(" || c == ")" || c == "<" || c == ">";
    endfunction
    function bit pairs(bit [7:0] a, bit [7:0] b);
      if (a == b && (a == "&" || a == "|" || a == ">" || a == "<" || a == ";")) return 1;
      return b == "&" && (a == "|" || a == ">" || a == "<");
    endfunction

    function void grow();
      if (cnt >= SpanMax) clip = 1;
      else cnt++;
    endfunction

    function void emit(stc_pkg::class_t k);
      span_t s;
      s.length = cnt[15:0]; s.cls = k; s.clipped = clip; s.eos = 0;
      owed.push_back(s);
      step_spans++;
      cnt = 0; clip = 0; mode = stc_pkg::M_IDLE;
    endfunction

    function void value_open(stc_pkg::mode_t m);
      if (word_start && expect_cmd) expect_cmd = 0;
      word_start = 0; mode = m; cnt = 1;
    endfunction

    function void op_close(bit [7:0] second);
      bit to_cmd;
      if (second == 0) to_cmd = pend_op == ";" || pend_op == "|" || pend_op == "&" ||
                                pend_op == "(";
      else to_cmd = (pend_op == second && (pend_op == ";" || pend_op == "|" ||
                     pend_op == "&")) || (pend_op == "|" && second == "&");
      if (to_cmd) expect_cmd = 1;
      word_start = 1;
      emit(stc_pkg::CL_OPERATOR);
    endfunction

    function void word_close();
      bit kw, kw_cmd, same;
      kw = 0; kw_cmd = 0;
      // Keyword lookup only on unclipped words that fit the prefix store.
      if (!clip && cnt <= 8) begin
        for (int k = 0; k < stc_pkg::KwCount; k++) begin
          if (stc_pkg::KwTable[k].len == cnt) begin
            same = 1;
            for (int i = 0; i < cnt; i++)
              if (stc_pkg::KwTable[k].text[63-8*i -: 8] != prefix[i]) same = 0;
            if (same) begin
              kw = 1; kw_cmd = stc_pkg::KwTable[k].to_cmd;
            end
          end
        end
      end
      word_start = 0;
      if (kw) begin
        expect_cmd = kw_cmd; emit(stc_pkg::CL_KEYWORD);
      end else if (expect_cmd && assign_track == 1) emit(stc_pkg::CL_VARIABLE);
      else if (expect_cmd) begin
        expect_cmd = 0; emit(stc_pkg::CL_COMMAND);
      end else if (dash_lead) emit(stc_pkg::CL_OPTION);
      else emit(stc_pkg::CL_PLAIN);
    endfunction

    function void word_add(bit [7:0] c);
      if (cnt < 8) prefix[cnt] = c;
      if (assign_track == 0) begin
        if (c == "=") assign_track = 1;
        else if (!nm(c)) assign_track = 2;
      end
      grow();
    endfunction

    // Returns 1 when the open token takes the byte.
    function bit carry_on(bit [7:0] c, bit fin);
      case (mode)
        stc_pkg::M_WS: begin
          if (!sp(c)) begin
            emit(stc_pkg::CL_PLAIN); return 0;
          end
          if (c == 8'h0a) expect_cmd = 1;
          grow(); return 1;
        end
        stc_pkg::M_COMMENT: begin
          if (c == 8'h0a) begin
            emit(stc_pkg::CL_COMMENT); return 0;
          end
          grow(); return 1;
        end
        stc_pkg::M_SQ: begin
          grow();
          if (c == "'") emit(stc_pkg::CL_STRING);
          return 1;
        end
        stc_pkg::M_DQ: begin
          grow();
          if (dq_esc) dq_esc = 0;
          else if (c == "\\" && !fin) dq_esc = 1;
          else if (c == "\"") emit(stc_pkg::CL_STRING);
          return 1;
        end
        stc_pkg::M_VSTART: begin
          grow();
          if (c == "{") mode = stc_pkg::M_VBRACE;
          else if (c == "(") begin
            depth = 1; mode = stc_pkg::M_VPAREN;
          end else if (nm(c)) mode = stc_pkg::M_VNAME;
          else emit(stc_pkg::CL_VARIABLE);
          return 1;
        end
        stc_pkg::M_VBRACE: begin
          grow();
          if (c == "}") emit(stc_pkg::CL_VARIABLE);
          return 1;
        end
        stc_pkg::M_VPAREN: begin
          grow();
          if (c == "(") begin
            if (depth < DepthMax) depth++;
          end else if (c == ")") begin
            if (depth > 0) depth--;
          end
          if (depth == 0) emit(stc_pkg::CL_VARIABLE);
          return 1;
        end
        stc_pkg::M_VNAME: begin
          if (!nm(c)) begin
            emit(stc_pkg::CL_VARIABLE); return 0;
          end
          grow(); return 1;
        end
        stc_pkg::M_ESC: begin
          grow(); emit(stc_pkg::CL_STRING); return 1;
        end
        stc_pkg::M_OP: begin
          if (pairs(pend_op, c)) begin
            grow(); op_close(c); return 1;
          end
          op_close(0); return 0;
        end
        stc_pkg::M_WORD: begin
          if (sp(c) || opc(c) || c == "'" || c == "\"" || c == "$" || c == "\\") begin
            word_close(); return 0;
          end
          word_add(c); return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void open_token(bit [7:0] c, bit fin);
      if (sp(c)) begin
        if (c == 8'h0a) expect_cmd = 1;
        word_start = 1; mode = stc_pkg::M_WS; cnt = 1;
      end else if (c == "#" && word_start) begin
        mode = stc_pkg::M_COMMENT; cnt = 1;
      end else if (c == "'") value_open(stc_pkg::M_SQ);
      else if (c == "\"") begin
        dq_esc = 0; value_open(stc_pkg::M_DQ);
      end else if (c == "$") value_open(stc_pkg::M_VSTART);
      else if (c == "\\" && !fin) value_open(stc_pkg::M_ESC);
      else if (opc(c)) begin
        pend_op = c; mode = stc_pkg::M_OP; cnt = 1;
      end else begin
        word_start = 0; mode = stc_pkg::M_WORD; cnt = 0;
        assign_track = (al(c) || c == "_") ? 2'd0 : 2'd2;
        dash_lead = (c == "-");
        if (c == "=") assign_track = 2;
        prefix[0] = c;
        grow();
      end
    endfunction

    // Notes one accepted input transfer and queues the spans it closes.
    function void note_byte(bit [7:0] c, bit fin);
      step_spans = 0;
      if (mode == stc_pkg::M_IDLE || !carry_on(c, fin)) open_token(c, fin);
      if (fin) begin
        case (mode)
          stc_pkg::M_WS: emit(stc_pkg::CL_PLAIN);
          stc_pkg::M_COMMENT: emit(stc_pkg::CL_COMMENT);
          stc_pkg::M_SQ, stc_pkg::M_DQ, stc_pkg::M_ESC: emit(stc_pkg::CL_STRING);
          stc_pkg::M_VSTART, stc_pkg::M_VBRACE, stc_pkg::M_VPAREN, stc_pkg::M_VNAME:
            emit(stc_pkg::CL_VARIABLE);
          stc_pkg::M_OP: op_close(0);
          stc_pkg::M_WORD: word_close();
          default: ;
        endcase
        if (step_spans > 0) owed[$].eos = 1;
        clear();
      end
    endfunction

    // Compares one output transfer with the oldest owed span.
    function void check_span(logic [15:0] len, logic [2:0] k, logic clp, logic eos);
      span_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected span: len=%0d class=%0d clip=%0b eos=%0b", len, k, clp, eos);
        return;
      end
      e = owed.pop_front();
      if (len !== e.length || k !== e.cls || clp !== e.clipped || eos !== e.eos) begin
        mismatches++;
        if (mismatches <= 10)
          $display("span mismatch: expected len=%0d class=%0d clip=%0b eos=%0b, got %0d %0d %0b %0b",
                   e.length, e.cls, e.clipped, e.eos, len, k, clp, eos);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_final_byte;
  logic [7:0]  in_text_byte;
  logic        out_valid, out_stall;
  logic [15:0] out_span_length;
  logic [2:0]  out_span_class;
  logic        out_length_clipped, out_end_of_source;

  span_scoreboard sb;
  int send_idle_pct, recv_stall_pct, sent, cycles;

  shell_token_classifier_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_text_byte, .in_final_byte,
    .out_valid, .out_stall, .out_span_length, .out_span_class,
    .out_length_clipped, .out_end_of_source
  );

  // 8 ns clock.
  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output monitor and run-time guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_span(out_span_length, out_span_class, out_length_clipped, out_end_of_source);
    if (cycles > LimitCycles) begin
      $display("shell_token_classifier_core verification failed");
      $finish;
    end
  end

  // Drives one byte and waits for its transfer.
  task automatic send_byte(input bit [7:0] c, input bit fin);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1; in_text_byte <= c; in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(c, fin);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input bit [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    bit [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Builds one random shell fragment, mostly well formed.
  function automatic void add_piece(ref bit [7:0] q[$]);
    string pieces[] = '{"if", "then", "fi", "do", "done", "while", "until", "case", "esac",
      "function", "functions", "select", "time", "in", "for", "else", "elif", "echo",
      "ls", "x=1", "_a=b", "a1=", "=x", "-v", "--long", "file.txt", " ", "  ", "\t",
      "\n", "#note here", "'sq str'", "\"dq \\\" x\"", "$name", "${a b}", "$((1)(2))",
      "$?", "$", "\\n", "\\", "&&", "||", ">>", "<<", ";;", "|&", ">&", "<&", "|", "&",
      ";", "(", ")", "<", ">", "'", "\"", "9x", "a-b", "{", "}"};
    string s;
    if ($urandom_range(9) == 0) begin
      q.push_back(8'($urandom_range(255)));
      return;
    end
    s = pieces[$urandom_range(pieces.size() - 1)];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    if ($urandom_range(2) == 0) q.push_back(" ");
  endfunction

  task automatic random_sources(input int budget);
    bit [7:0] q[$];
    int start;
    start = sent;
    while (sent - start < budget) begin
      q.delete();
      repeat ($urandom_range(1, 12)) add_piece(q);
      send_bytes(q);
    end
  endtask

  initial begin
    bit [7:0] q[$];
    int pcts[4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{8, 8}};
    sb = new();
    cycles = 0; sent = 0; send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 0; in_valid = 0; in_text_byte = 0; in_final_byte = 0; out_stall = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed sources: edge bytes and the end-of-source corner cases.
    send_text("if x=1 ;");
    send_text("ls -l|&\"a\\");
    send_text("\\");
    send_text("$");
    send_text("'open");
    send_text("a>");
    q = '{8'h00, 8'hff, 8'h80, 8'h7f};
    send_bytes(q);
    drain();

    // Random phases over the idling patterns.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p][0]; recv_stall_pct = pcts[p][1];
      random_sources(95);
      drain();
    end

    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0)
      $display("shell_token_classifier_core verification clean");
    else
      $display("shell_token_classifier_core verification failed");
    $finish;
  end
endmodule
